// ----- hdl/sma_pkg.sv -----
// Shared constants and codes for the shadow memory access checker.
`default_nettype none
package sma_pkg;

  localparam int GRANULE_SHIFT = 3;
  localparam int SHADOW_DEPTH  = 65536;
  localparam int MAX_LEN       = 4096;

  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 13;
  localparam int SHADOW_W = 8;
  localparam int IDX_W    = $clog2(SHADOW_DEPTH);
  // Granule index of a 33-bit relative address.
  localparam int GIDX_W   = ADDR_W + 1 - GRANULE_SHIFT;

  localparam logic [1:0] MODE_CHECK    = 2'd0;
  localparam logic [1:0] MODE_POISON   = 2'd1;
  localparam logic [1:0] MODE_UNPOISON = 2'd2;
  localparam logic [1:0] MODE_IGNORED  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_POISON  = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

endpackage
`default_nettype wire

// ----- hdl/sma_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module sma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/shadow_memory_access_checker.sv -----
// Top level of the shadow memory access checker: control sequencer around the shadow RAM.
//
// One signed shadow byte is kept per 8-byte granule above the window base on cfg_wdata.
// A request on the in_ channel is a check (mode 0), a poison fill (mode 1), an
// unpoison fill (mode 2) or ignored (mode 3); every request yields exactly one result
// on the out_ channel with a status and an echo of the write flag, address and the
// clamped length. The block works on one request at a time. in_ready is high while the
// sequencer idles. A zero-length, ignored or below-window request goes from S_PREP
// straight to S_DONE, and one that runs past the window end passes S_PREP and S_SPAN.
// A check passes S_PREP and S_SPAN, then scans its shadow bytes in S_CHECK up to the
// first poisoned one; a fill writes its whole granules in S_FILL, and an unpoison also
// the tail granule. The shadow RAM port, one granule per cycle, sets the pace. A new
// request can be taken the cycle after the result is registered.
// The result sits in an output register, so a stalled receiver does not block the next
// request; only the result after that waits until out_ready takes the held one.
// After reset the shadow RAM is cleared, one entry per cycle; in_ready stays low during
// that pass. The window base resets to zero and may be written through cfg_we / cfg_wdata
// at any time the block is idle.
`default_nettype none
module shadow_memory_access_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [sma_pkg::ADDR_W-1:0]    cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [sma_pkg::ADDR_W-1:0]    in_address,
  input  wire logic [sma_pkg::LEN_W-1:0]     in_length,
  input  wire logic                          in_write,
  input  wire logic signed [sma_pkg::SHADOW_W-1:0] in_poison_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_status,
  output logic                               out_was_write,
  output logic [sma_pkg::ADDR_W-1:0]         out_fault_address,
  output logic [sma_pkg::LEN_W-1:0]          out_fault_length
);
  import sma_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_PREP  = 7'b0000100,
    S_SPAN  = 7'b0001000,
    S_FILL  = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  localparam logic [IDX_W:0]  CLEAR_LAST = (IDX_W+1)'(SHADOW_DEPTH - 1);
  localparam logic [GIDX_W-1:0] DEPTH_G  = GIDX_W'(SHADOW_DEPTH);
  localparam logic [LEN_W-1:0] MAX_LEN_V = LEN_W'(MAX_LEN);

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]        base_r;
  logic [1:0]               mode_r;
  logic [ADDR_W-1:0]        addr_r;
  logic [LEN_W-1:0]         len_r;
  logic                     wr_r;
  logic [SHADOW_W-1:0]      code_r;
  logic [ADDR_W-1:0]        rel_r, rel_nxt;
  logic [LEN_W-1:0]         lenm1_r, lenm1_nxt;
  logic [IDX_W:0]           cur_r, cur_nxt;
  logic [IDX_W:0]           stop_r, stop_nxt;
  logic [GRANULE_SHIFT-1:0] off_r, off_nxt;
  logic [1:0]               status_r, status_nxt;

  logic                     out_valid_r;
  logic [1:0]               out_status_r;
  logic                     out_was_write_r;
  logic [ADDR_W-1:0]        out_addr_r;
  logic [LEN_W-1:0]         out_len_r;

  logic                     accept;
  logic                     out_load;
  logic [LEN_W-1:0]         len_clamped;

  logic [ADDR_W:0]          sum_end;
  logic [ADDR_W:0]          sum_last;
  logic [GIDX_W-1:0]        first_idx;
  logic [GIDX_W-1:0]        last_idx;
  logic [GIDX_W-1:0]        end_idx;
  logic [GRANULE_SHIFT-1:0] tail;
  logic                     unpoison;
  logic                     tail_wr;

  logic                     ram_we;
  logic [SHADOW_W-1:0]      ram_wdata;
  logic                     ram_re;
  logic [SHADOW_W-1:0]      ram_rdata;
  logic signed [SHADOW_W-1:0] last_val;
  logic signed [SHADOW_W-1:0] last_off;

  assign accept      = in_valid && in_ready;
  assign in_ready    = (state_r == S_IDLE);
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign len_clamped = (in_length > MAX_LEN_V) ? MAX_LEN_V : in_length;

  // Span arithmetic on the relative start address.
  assign sum_end   = {1'b0, rel_r} + {{(ADDR_W+1-LEN_W){1'b0}}, len_r};
  assign sum_last  = {1'b0, rel_r} + {{(ADDR_W+1-LEN_W){1'b0}}, lenm1_r};
  assign first_idx = {1'b0, rel_r[ADDR_W-1:GRANULE_SHIFT]};
  assign last_idx  = sum_last[ADDR_W:GRANULE_SHIFT];
  assign end_idx   = sum_end[ADDR_W:GRANULE_SHIFT];
  assign tail      = len_r[GRANULE_SHIFT-1:0];
  assign unpoison  = (mode_r == MODE_UNPOISON);
  assign tail_wr   = unpoison && (tail != '0);

  assign last_val = $signed(ram_rdata);
  assign last_off = $signed({{(SHADOW_W-GRANULE_SHIFT){1'b0}}, off_r});

  always_comb begin
    state_nxt  = state_r;
    rel_nxt    = rel_r;
    lenm1_nxt  = lenm1_r;
    cur_nxt    = cur_r;
    stop_nxt   = stop_r;
    off_nxt    = off_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_wdata  = '0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we  = 1'b1;
        cur_nxt = cur_r + 1'b1;
        if (cur_r == CLEAR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        rel_nxt   = addr_r - base_r;
        lenm1_nxt = len_r - 1'b1;
        if (len_r == '0 || mode_r == MODE_IGNORED) begin
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
        end else if (addr_r < base_r) begin
          status_nxt = ST_OUTSIDE;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SPAN;
        end
      end
      S_SPAN: begin
        status_nxt = ST_OK;
        if (mode_r == MODE_CHECK) begin
          if (last_idx >= DEPTH_G) begin
            status_nxt = ST_OUTSIDE;
            state_nxt  = S_DONE;
          end else begin
            cur_nxt   = first_idx[IDX_W:0];
            stop_nxt  = last_idx[IDX_W:0];
            off_nxt   = sum_last[GRANULE_SHIFT-1:0];
            state_nxt = S_CHECK;
          end
        end else begin
          // An unpoison with a tail also writes the granule at the end index.
          if ((tail_wr && end_idx >= DEPTH_G) || (!tail_wr && end_idx > DEPTH_G)) begin
            status_nxt = ST_OUTSIDE;
            state_nxt  = S_DONE;
          end else begin
            cur_nxt   = first_idx[IDX_W:0];
            stop_nxt  = end_idx[IDX_W:0];
            state_nxt = S_FILL;
          end
        end
      end
      S_FILL: begin
        if (cur_r != stop_r) begin
          ram_we    = 1'b1;
          ram_wdata = unpoison ? '0 : code_r;
          cur_nxt   = cur_r + 1'b1;
        end else begin
          ram_we    = tail_wr;
          ram_wdata = {{(SHADOW_W-GRANULE_SHIFT){1'b0}}, tail};
          state_nxt = S_DONE;
        end
      end
      S_CHECK: begin
        // Read data here belongs to granule cur_r; the next read is already issued.
        if (cur_r != stop_r) begin
          if (ram_rdata != '0) begin
            status_nxt = ST_POISON;
            state_nxt  = S_DONE;
          end else begin
            cur_nxt = cur_r + 1'b1;
          end
        end else begin
          if (last_val != '0 && last_off >= last_val) begin
            status_nxt = ST_POISON;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A read is issued for the granule that the check evaluates in the next cycle.
  assign ram_re = (state_nxt == S_CHECK);

  sma_ram #(
    .WIDTH (SHADOW_W),
    .DEPTH (SHADOW_DEPTH)
  ) u_shadow (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_r[IDX_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cur_nxt[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cur_r       <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      addr_r <= in_address;
      len_r  <= len_clamped;
      wr_r   <= in_write;
      code_r <= in_poison_value;
    end
    rel_r    <= rel_nxt;
    lenm1_r  <= lenm1_nxt;
    stop_r   <= stop_nxt;
    off_r    <= off_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_status_r    <= status_r;
      out_was_write_r <= wr_r;
      out_addr_r      <= addr_r;
      out_len_r       <= len_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_was_write     = out_was_write_r;
  assign out_fault_address = out_addr_r;
  assign out_fault_length  = out_len_r;

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Testbench for the shadow memory access checker, with a shadow store model and result checks.
module tb;
  import sma_pkg::*;

  localparam int unsigned WINDOW_BYTES = SHADOW_DEPTH << GRANULE_SHIFT;
  localparam longint unsigned GRAN_MASK = (64'd1 << GRANULE_SHIFT) - 64'd1;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int LONG_HOLD_OFF = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [1:0]                   mode;
    logic [ADDR_W-1:0]            address;
    logic [LEN_W-1:0]             length;
    logic                         write_op;
    logic signed [SHADOW_W-1:0]   poison_value;
  } request_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              was_write;
    logic [ADDR_W-1:0] fault_address;
    logic [LEN_W-1:0]  fault_length;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = MODE_CHECK;
  logic [ADDR_W-1:0] in_address = '0;
  logic [LEN_W-1:0] in_length = '0;
  logic in_write = 1'b0;
  logic signed [SHADOW_W-1:0] in_poison_value = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic [1:0] out_status;
  logic out_was_write;
  logic [ADDR_W-1:0] out_fault_address;
  logic [LEN_W-1:0] out_fault_length;

  // Model of the block's state.
  logic signed [SHADOW_W-1:0] shadow_model [SHADOW_DEPTH];
  logic [ADDR_W-1:0] window_base_model = '0;

  result_t pending_results [$];
  int failures = 0;
  int items_sent = 0;
  int cycle_count = 0;

  // Traffic shaping knobs shared by the test tasks, the sender task and the receiver process.
  bit sender_gaps_on = 1'b0;
  int burst_left = 0;
  bit rx_stall_on = 1'b0;
  bit hold_off_request = 1'b0;

  shadow_memory_access_checker DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_address        (in_address),
    .in_length         (in_length),
    .in_write          (in_write),
    .in_poison_value   (in_poison_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_was_write     (out_was_write),
    .out_fault_address (out_fault_address),
    .out_fault_length  (out_fault_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one request to the shadow model and returns the result it must produce.
  function automatic result_t predict_request(input request_t req);
    result_t res;
    logic [LEN_W-1:0] len;
    longint unsigned rel, last_pos, first_idx, last_idx, end_idx, tail, idx;
    logic signed [SHADOW_W-1:0] last_code;
    logic unpoison;
    len = (req.length > MAX_LEN) ? LEN_W'(MAX_LEN) : req.length;
    res.status = ST_OK;
    res.was_write = req.write_op;
    res.fault_address = req.address;
    res.fault_length = len;
    if (len == 0 || req.mode == MODE_IGNORED) return res;
    if (req.address < window_base_model) begin
      res.status = ST_OUTSIDE;
      return res;
    end
    rel = 64'(req.address) - 64'(window_base_model);
    if (req.mode == MODE_CHECK) begin
      last_pos = rel + len - 1;
      first_idx = rel >> GRANULE_SHIFT;
      last_idx = last_pos >> GRANULE_SHIFT;
      if (last_idx >= SHADOW_DEPTH) begin
        res.status = ST_OUTSIDE;
        return res;
      end
      for (idx = first_idx; idx < last_idx; idx++)
        if (shadow_model[idx] != 0) res.status = ST_POISON;
      // The last granule may be partly accessible: its code is the count of usable bytes.
      last_code = shadow_model[last_idx];
      if (last_code != 0 && int'(last_pos & GRAN_MASK) >= int'(last_code))
        res.status = ST_POISON;
      return res;
    end
    unpoison = (req.mode == MODE_UNPOISON);
    end_idx = (rel + len) >> GRANULE_SHIFT;
    tail = len & GRAN_MASK;
    if ((unpoison && tail != 0 && end_idx >= SHADOW_DEPTH) || end_idx > SHADOW_DEPTH) begin
      res.status = ST_OUTSIDE;
    end else begin
      for (idx = rel >> GRANULE_SHIFT; idx < end_idx; idx++)
        shadow_model[idx] = unpoison ? '0 : req.poison_value;
      if (unpoison && tail != 0) shadow_model[end_idx] = SHADOW_W'(tail);
    end
    return res;
  endfunction

  task automatic send_request(input logic [1:0] mode, input logic [ADDR_W-1:0] address,
                              input logic [LEN_W-1:0] length, input logic write_op,
                              input logic signed [SHADOW_W-1:0] code);
    request_t req;
    int gap;
    req.mode = mode;
    req.address = address;
    req.length = length;
    req.write_op = write_op;
    req.poison_value = code;
    if (sender_gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_mode <= req.mode;
    in_address <= req.address;
    in_length <= req.length;
    in_write <= req.write_op;
    in_poison_value <= req.poison_value;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    pending_results.push_back(predict_request(req));
    items_sent++;
  endtask

  // Drops valid and waits until every outstanding request has returned its result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_window_base(input logic [ADDR_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_base_model = value;
  endtask

  task automatic test_directed_cases();
    // The shadow RAM is cleared after reset; in_ready rises once that pass is done.
    while (in_ready !== 1'b1) @(posedge clk);
    write_window_base('0);
    send_request(MODE_CHECK, 32'h0000_0000, 13'd0, 1'b0, 8'sd0);
    send_request(MODE_POISON, 32'h0000_0040, 13'd0, 1'b0, -8'sd1);
    send_request(MODE_CHECK, 32'h0000_0000, 13'd1, 1'b1, 8'sd0);
    send_request(MODE_POISON, 32'h0000_0040, 13'd16, 1'b0, -8'sd128);
    send_request(MODE_CHECK, 32'h0000_0040, 13'd1, 1'b0, 8'sd0);
    send_request(MODE_CHECK, 32'h0000_0038, 13'd8, 1'b1, 8'sd0);
    send_request(MODE_CHECK, 32'h0000_0038, 13'd9, 1'b0, 8'sd0);
    send_request(MODE_UNPOISON, 32'h0000_0040, 13'd13, 1'b0, 8'sd0);
    send_request(MODE_CHECK, 32'h0000_0048, 13'd5, 1'b0, 8'sd0);
    send_request(MODE_CHECK, 32'h0000_0048, 13'd6, 1'b1, 8'sd0);
    // A positive code larger than the granule leaves the whole granule readable.
    send_request(MODE_POISON, 32'h0000_0080, 13'd8, 1'b0, 8'sd127);
    send_request(MODE_CHECK, 32'h0000_0080, 13'd8, 1'b0, 8'sd0);
    send_request(MODE_CHECK, 32'h0000_0080, 13'd9, 1'b0, 8'sd0);
    send_request(MODE_POISON, 32'h0000_0103, 13'd10, 1'b0, -8'sd1);
    send_request(MODE_CHECK, 32'h0000_0100, 13'd8, 1'b0, 8'sd0);
    send_request(MODE_IGNORED, 32'h0000_0100, 13'd8, 1'b1, 8'sd85);
    send_request(MODE_CHECK, 32'h0000_0100, 13'd1, 1'b0, 8'sd0);
    send_request(MODE_CHECK, 32'h0000_0000, 13'd4096, 1'b0, 8'sd0);
    send_request(MODE_UNPOISON, 32'h0000_0000, 13'd8191, 1'b1, 8'sd0);
    send_request(MODE_CHECK, 32'h0000_0000, 13'd8191, 1'b1, 8'sd0);
    send_request(MODE_CHECK, WINDOW_BYTES - 1, 13'd1, 1'b0, 8'sd0);
    send_request(MODE_CHECK, WINDOW_BYTES - 1, 13'd2, 1'b0, 8'sd0);
    send_request(MODE_POISON, WINDOW_BYTES - 8, 13'd8, 1'b0, -8'sd8);
    send_request(MODE_UNPOISON, WINDOW_BYTES - 8, 13'd9, 1'b0, 8'sd0);
    send_request(MODE_CHECK, 32'hFFFF_FFFF, 13'd1, 1'b1, 8'sd0);
  endtask

  task automatic test_window_extremes();
    wait_idle();
    write_window_base(32'hFFFF_FFFF);
    send_request(MODE_CHECK, 32'hFFFF_FFFF, 13'd1, 1'b0, 8'sd0);
    send_request(MODE_CHECK, 32'hFFFF_FFFE, 13'd1, 1'b1, 8'sd0);
    send_request(MODE_UNPOISON, 32'hFFFF_FFFF, 13'd1, 1'b0, 8'sd0);
    send_request(MODE_CHECK, 32'hFFFF_FFFF, 13'd1, 1'b0, 8'sd0);
    send_request(MODE_POISON, 32'hFFFF_FFFF, 13'd8, 1'b0, -8'sd4);
    send_request(MODE_CHECK, 32'hFFFF_FFFF, 13'd2, 1'b0, 8'sd0);
    wait_idle();
    write_window_base(32'hFFFF_FFF8);
    send_request(MODE_CHECK, 32'hFFFF_FFF8, 13'd8, 1'b0, 8'sd0);
    send_request(MODE_UNPOISON, 32'hFFFF_FFF8, 13'd8, 1'b1, 8'sd0);
    send_request(MODE_CHECK, 32'hFFFF_FFF8, 13'd8, 1'b0, 8'sd0);
    send_request(MODE_CHECK, 32'hFFFF_FFF0, 13'd16, 1'b0, 8'sd0);
  endtask

  // Allocation-like episodes: poison a span with redzones, open the object, probe around it.
  task automatic test_random_traffic();
    logic [ADDR_W-1:0] bases [5];
    int unsigned hot_rel, obj_rel, obj_len, off, acc_len;
    int p, pick, phase_end;
    bases[0] = '0;
    bases[1] = $urandom & 32'hFFFF_FFF8;
    bases[2] = 32'h8000_0000;
    bases[3] = $urandom;
    bases[4] = 32'hFFFC_0000;
    for (p = 0; p < 5; p++) begin
      wait_idle();
      write_window_base(bases[p]);
      sender_gaps_on = (p != 0);
      rx_stall_on = (p != 0 && p != 3);
      hot_rel = $urandom_range(0, WINDOW_BYTES - 8192);
      phase_end = items_sent + 80;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(2'($urandom), $urandom, 13'($urandom), 1'($urandom), 8'($urandom));
        end else begin
          pick = $urandom_range(0, 9);
          if (pick < 7) obj_rel = hot_rel + $urandom_range(0, 4095);
          else if (pick < 9) obj_rel = WINDOW_BYTES - $urandom_range(1, 256);
          else obj_rel = $urandom_range(0, WINDOW_BYTES - 1);
          if ($urandom_range(0, 3) != 0) obj_rel = obj_rel & ~32'd7;
          pick = $urandom_range(0, 99);
          if (pick < 70) obj_len = $urandom_range(1, 24);
          else if (pick < 92) obj_len = $urandom_range(25, 160);
          else if (pick < 98) obj_len = $urandom_range(161, 1024);
          else obj_len = $urandom_range(1025, 4000);
          send_request(MODE_POISON, bases[p] + obj_rel - 16, LEN_W'(obj_len + 32),
                       1'($urandom), 8'($urandom));
          send_request(MODE_UNPOISON, bases[p] + obj_rel, LEN_W'(obj_len),
                       1'($urandom), 8'($urandom));
          repeat ($urandom_range(2, 6)) begin
            off = $urandom_range(0, obj_len + 24);
            pick = $urandom_range(0, 19);
            if (pick == 0) acc_len = 0;
            else if (pick < 17) acc_len = $urandom_range(1, 16);
            else acc_len = $urandom_range(17, 64);
            send_request(MODE_CHECK, bases[p] + obj_rel + off - 12, LEN_W'(acc_len),
                         1'($urandom), 8'($urandom));
          end
          if ($urandom_range(0, 2) == 0)
            send_request(MODE_POISON, bases[p] + obj_rel, LEN_W'(obj_len),
                         1'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  // The receiver stops taking results for a long time while requests keep coming.
  task automatic test_backpressure();
    int n;
    int unsigned rel;
    wait_idle();
    write_window_base(32'h0000_1000);
    sender_gaps_on = 1'b0;
    rx_stall_on = 1'b0;
    hold_off_request = 1'b1;
    for (n = 0; n < 24; n++) begin
      rel = $urandom_range(0, 255);
      send_request((n % 3 == 0) ? MODE_POISON : (n % 3 == 1) ? MODE_UNPOISON : MODE_CHECK,
                   32'h0000_1000 + rel, LEN_W'($urandom_range(1, 32)),
                   1'($urandom), 8'($urandom));
    end
  endtask

  initial begin : receiver
    logic [15:0] ready_pattern;
    int pattern_pos;
    ready_pattern = '1;
    pattern_pos = 0;
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_OFF) @(posedge clk);
      end else begin
        if (pattern_pos == 0) ready_pattern = 16'($urandom) | 16'($urandom);
        out_ready <= !rx_stall_on || ready_pattern[pattern_pos];
        pattern_pos = (pattern_pos + 1) % 16;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d address %h",
               out_status, out_fault_address);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          failures++;
        end
        if (out_was_write !== want.was_write) begin
          $error("was_write: expected %0d, got %0d", want.was_write, out_was_write);
          failures++;
        end
        if (out_fault_address !== want.fault_address) begin
          $error("fault_address: expected %h, got %h", want.fault_address, out_fault_address);
          failures++;
        end
        if (out_fault_length !== want.fault_length) begin
          $error("fault_length: expected %0d, got %0d", want.fault_length, out_fault_length);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL shadow_memory_access_checker");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SHADOW_DEPTH; i++) shadow_model[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_window_extremes();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) $display("PASS shadow_memory_access_checker");
    else $display("FAIL shadow_memory_access_checker");
    $finish;
  end

endmodule
